// ===== design/md5_pkg.sv =====
// Shared types, constants and round tables for the MD5 stream hasher.
package md5_pkg;

  localparam int LANES      = 4;
  localparam int WORDS      = 16;
  localparam int WORD_AW    = 4;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] MD5_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_CSTART,
    ST_CROUND,
    ST_CFIN,
    ST_DONE
  } md5_state_t;

  typedef struct packed {
    logic take_byte;
    logic pad_start;
    logic pad_zero_start;
    logic pad_write;
    logic len_block;
    logic comp_start;
    logic comp_round;
    logic comp_finish;
    logic out_load;
  } md5_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_late;
    logic pad_last;
    logic round_last;
    logic out_free;
  } md5_stat_t;

  // Message word index used by round r
  function automatic logic [WORD_AW-1:0] md5_msg_index(logic [5:0] r);
    logic [WORD_AW-1:0] i;
    i = r[3:0];
    case (r[5:4])
      2'd0:    return i;
      2'd1:    return WORD_AW'(i * 4'd5 + 4'd1);
      2'd2:    return WORD_AW'(i * 4'd3 + 4'd5);
      default: return WORD_AW'(i * 4'd7);
    endcase
  endfunction

  function automatic logic [4:0] md5_rot_amount(logic [5:0] r);
    return ROT_S[{r[5:4], r[1:0]}];
  endfunction

  function automatic logic [31:0] md5_swap32(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ===== design/md5_if.sv =====
// Handshake channels for message bytes and digests.
interface md5_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source(output valid, data_byte, has_byte, last, input ready);
  modport sink(input valid, data_byte, has_byte, last, output ready);
endinterface

interface md5_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_high;
  logic [63:0] digest_low;

  modport source(output valid, digest_high, digest_low, input ready);
  modport sink(input valid, digest_high, digest_low, output ready);
endinterface

// ===== design/md5_ram.sv =====
// Generic simple dual-port RAM with registered read.
module md5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/md5_ctrl.sv =====
// Sequencer for byte intake, padding, compression and digest hand-off.
module md5_ctrl import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  input  logic      msg_has_byte,
  input  logic      msg_last,
  output logic      msg_ready,
  input  md5_stat_t stat,
  output md5_cmd_t  cmd
);

  md5_state_t state, state_next;
  logic pad_pend, pad_pend_next;
  logic in_pad, in_pad_next;
  logic second, second_next;
  logic len_block;

  assign len_block = !stat.fill_late || second;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pad_pend <= 1'b0;
      in_pad   <= 1'b0;
      second   <= 1'b0;
    end else begin
      state    <= state_next;
      pad_pend <= pad_pend_next;
      in_pad   <= in_pad_next;
      second   <= second_next;
    end
  end

  always_comb begin
    state_next    = state;
    pad_pend_next = pad_pend;
    in_pad_next   = in_pad;
    second_next   = second;
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          if (msg_has_byte && stat.fill_last) begin
            state_next    = ST_CSTART;
            pad_pend_next = msg_last;
          end else if (msg_last) begin
            state_next  = ST_PAD;
            in_pad_next = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (stat.pad_last) state_next = ST_CSTART;
      end
      ST_CSTART: state_next = ST_CROUND;
      ST_CROUND: begin
        if (stat.round_last) state_next = ST_CFIN;
      end
      ST_CFIN: begin
        if (pad_pend) begin
          state_next    = ST_PAD;
          pad_pend_next = 1'b0;
          in_pad_next   = 1'b1;
        end else if (in_pad && len_block) begin
          state_next = ST_DONE;
        end else if (in_pad) begin
          state_next  = ST_PAD;
          second_next = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next  = ST_IDLE;
          in_pad_next = 1'b0;
          second_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.len_block = len_block;
    msg_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        msg_ready     = 1'b1;
        cmd.take_byte = msg_valid && msg_has_byte;
        cmd.pad_start = msg_valid && msg_last && !(msg_has_byte && stat.fill_last);
      end
      ST_PAD:    cmd.pad_write  = 1'b1;
      ST_CSTART: cmd.comp_start = 1'b1;
      ST_CROUND: cmd.comp_round = 1'b1;
      ST_CFIN: begin
        cmd.comp_finish    = 1'b1;
        cmd.pad_start      = pad_pend;
        cmd.pad_zero_start = !pad_pend && in_pad && !len_block;
      end
      ST_DONE:   cmd.out_load = stat.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== design/md5_dp.sv =====
// Block buffer, round logic, chaining words, length count and digest register.
module md5_dp import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md5_cmd_t    cmd,
  output md5_stat_t   stat,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_high,
  output logic [63:0] digest_low
);

  logic [5:0]         fill, fill_next;
  logic [63:0]        bit_len;
  logic [WORD_AW-1:0] pad_ptr;
  logic               pad_first;
  logic [5:0]         round_idx;
  logic [31:0]        chain [4];
  logic [31:0]        wa, wb, wc, wd;

  logic [LANES-1:0]   lane_we;
  logic [7:0]         lane_wdata [LANES];
  logic [7:0]         lane_rdata [LANES];
  logic [WORD_AW-1:0] waddr, raddr;
  logic [5:0]         rd_round;

  logic [31:0]        m_word, f_val, t_val, k_val;
  logic [4:0]         s_val;
  logic [63:0]        rot_w;

  assign fill_next = cmd.take_byte ? 6'(fill + 6'd1) : fill;

  assign stat.fill_last  = (fill == 6'd63);
  assign stat.fill_late  = (fill[5:3] == 3'b111);
  assign stat.pad_last   = (pad_ptr == WORD_AW'(WORDS - 1));
  assign stat.round_last = (round_idx == 6'd63);
  assign stat.out_free   = !out_valid || out_ready;

  // Byte lanes of the block buffer; lane k holds byte 4w+k of word w
  assign waddr    = cmd.take_byte ? fill[5:2] : pad_ptr;
  assign rd_round = cmd.comp_start ? 6'd0 : 6'(round_idx + 6'd1);
  assign raddr    = md5_msg_index(rd_round);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_we[k]    = 1'b0;
      lane_wdata[k] = data_byte;
      if (cmd.take_byte) begin
        lane_we[k] = (fill[1:0] == 2'(k));
      end else if (cmd.pad_write) begin
        lane_we[k] = !(pad_first && (2'(k) < fill[1:0]));
        if (cmd.len_block && pad_ptr == WORD_AW'(WORDS - 2)) begin
          lane_wdata[k] = bit_len[8*k +: 8];
        end else if (cmd.len_block && pad_ptr == WORD_AW'(WORDS - 1)) begin
          lane_wdata[k] = bit_len[32 + 8*k +: 8];
        end else if (pad_first && fill[1:0] == 2'(k)) begin
          lane_wdata[k] = PAD_BYTE;
        end else begin
          lane_wdata[k] = 8'h00;
        end
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    md5_ram #(.WIDTH(8), .DEPTH(WORDS)) u_lane (
      .clk   (clk),
      .we    (lane_we[k]),
      .waddr (waddr),
      .wdata (lane_wdata[k]),
      .raddr (raddr),
      .rdata (lane_rdata[k])
    );
  end

  // One MD5 round
  assign m_word = {lane_rdata[3], lane_rdata[2], lane_rdata[1], lane_rdata[0]};
  assign k_val  = ROUND_K[round_idx];
  assign s_val  = md5_rot_amount(round_idx);

  always_comb begin
    case (round_idx[5:4])
      2'd0:    f_val = (wb & wc) | (~wb & wd);
      2'd1:    f_val = (wd & wb) | (~wd & wc);
      2'd2:    f_val = wb ^ wc ^ wd;
      default: f_val = wc ^ (wb | ~wd);
    endcase
  end

  assign t_val = f_val + wa + k_val + m_word;
  assign rot_w = {t_val, t_val} << s_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_len   <= '0;
      round_idx <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 4; k++) chain[k] <= MD5_IV[k];
    end else begin
      fill <= fill_next;
      if (cmd.take_byte) bit_len <= bit_len + 64'd8;

      if (cmd.comp_start) begin
        round_idx <= '0;
      end else if (cmd.comp_round) begin
        round_idx <= 6'(round_idx + 6'd1);
      end

      if (cmd.comp_finish) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
        fill      <= '0;
        bit_len   <= '0;
        for (int k = 0; k < 4; k++) chain[k] <= MD5_IV[k];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working words, pad pointer and digest payload
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
    end else if (cmd.comp_round) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= wb + rot_w[63:32];
    end

    if (cmd.pad_start) begin
      pad_ptr   <= fill_next[5:2];
      pad_first <= 1'b1;
    end else if (cmd.pad_zero_start) begin
      pad_ptr   <= '0;
      pad_first <= 1'b0;
    end else if (cmd.pad_write) begin
      pad_ptr   <= WORD_AW'(pad_ptr + 1'b1);
      pad_first <= 1'b0;
    end

    if (cmd.out_load) begin
      digest_high <= {md5_swap32(chain[0]), md5_swap32(chain[1])};
      digest_low  <= {md5_swap32(chain[2]), md5_swap32(chain[3])};
    end
  end

endmodule

// ===== design/md5_stream_hasher_top.sv =====
// Top level of the byte-stream MD5 hasher: sequencer plus datapath.
//
//   channel  | dir | payload                         | handshake
//   ---------+-----+---------------------------------+------------------
//   msg      | in  | data_byte[7:0], has_byte, last  | valid / ready
//   digest   | out | digest_high[63:0], digest_low   | valid / ready
//
// Sequence: a byte item is written into the block buffer; the item that
// completes a 64-byte block adds operand fetch, 64 rounds on the single
// shared round unit and the chaining add. An item marked last adds pad
// words from the current word on plus a compression, another padded block
// when fewer than 9 bytes remain for pad byte and length, and a digest load.
// Reset: rst is synchronous; chaining words return to the MD5 initial values.
// Stalls: the digest sits in its own register, so intake resumes while it
// waits; a new digest holds in the sequencer until that register frees up.
module md5_stream_hasher_top import md5_pkg::*; (
  input logic         clk,
  input logic         rst,
  md5_msg_if.sink     msg,
  md5_digest_if.source digest
);

  md5_cmd_t  cmd;
  md5_stat_t stat;

  // Sequencer: accepts items only between messages blocks and padding
  md5_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg.valid),
    .msg_has_byte (msg.has_byte),
    .msg_last     (msg.last),
    .msg_ready    (msg.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Datapath: block buffer lanes, round unit, length counter, digest register
  md5_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_byte   (msg.data_byte),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .digest_high (digest.digest_high),
    .digest_low  (digest.digest_low)
  );

endmodule
